// File: rtl/sstft_pkg.sv
// ----------------------------------------------------------------------------
// sstft_pkg
// Shared types, constants and twiddle tables of the streaming STFT core.
// ----------------------------------------------------------------------------
package sstft_pkg;

  localparam int unsigned FftSizeDefault = 64;
  localparam int unsigned OvlW = 6;
  localparam int unsigned FrameW = 16;
  localparam int unsigned BinW = 6;
  localparam int unsigned SampW = 16;
  localparam int unsigned AccW = 64;

  localparam logic CmdWin  = 1'b0;
  localparam logic CmdSamp = 1'b1;

  // Decoded item handed from the front end to the transform engine.
  typedef struct packed {
    logic        is_sample;
    logic [5:0]  index;
    logic [15:0] value;
    logic        fire;
  } job_t;

  // Quarter-wave cosine, Q1.15 (1.0 = 32768), index 0..16.
  function automatic logic signed [17:0] qcos(input logic [4:0] i);
    logic signed [17:0] v;
    case (i)
      5'd0:  v = 18'sd32768;
      5'd1:  v = 18'sd32610;
      5'd2:  v = 18'sd32138;
      5'd3:  v = 18'sd31357;
      5'd4:  v = 18'sd30274;
      5'd5:  v = 18'sd28899;
      5'd6:  v = 18'sd27246;
      5'd7:  v = 18'sd25330;
      5'd8:  v = 18'sd23170;
      5'd9:  v = 18'sd20788;
      5'd10: v = 18'sd18205;
      5'd11: v = 18'sd15447;
      5'd12: v = 18'sd12540;
      5'd13: v = 18'sd9512;
      5'd14: v = 18'sd6393;
      5'd15: v = 18'sd3212;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] cos64(input logic [5:0] m);
    logic [4:0] r;
    logic signed [17:0] v;
    r = {1'b0, m[3:0]};
    case (m[5:4])
      2'd0:    v = qcos(r);
      2'd1:    v = -qcos(5'd16 - r);
      2'd2:    v = -qcos(r);
      default: v = qcos(5'd16 - r);
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] sin64(input logic [5:0] m);
    return cos64(m + 6'd48);
  endfunction

endpackage

// File: rtl/streaming_spectrogram_stft_core.sv
// ----------------------------------------------------------------------------
// streaming_spectrogram_stft_core
// Streaming spectrogram: windowed DFT frames emitted bin by bin.
// ----------------------------------------------------------------------------
// A firing sample starts a product pass over the frame; the bins follow it.
// Each bin runs the serial multiply-accumulate loop, registers the result and
// hands it off, so a frame holds the engine for the product pass and N/2+1
// bins plus output stalls; other words are taken while the engine is idle.
// Reset (rst_ni low, asynchronous) clears counts, queue and control state;
// sample and window stores hold no reset value.
module streaming_spectrogram_stft_core #(
  parameter int unsigned FftSize = sstft_pkg::FftSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // coeff_index[5:0], window_coeff[21:6], sample[37:22]
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // frame_number, bin_number, bin_real, bin_imag
  output logic        m_axis_tlast   // last_bin
);
  import sstft_pkg::*;

  logic [5:0]  ovl_q;
  logic        jv, jr;
  job_t        job;
  logic [15:0] fr;
  logic [5:0]  bn;
  logic [31:0] re, im;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovl_q <= '0;
    else if (cfg_valid_i) ovl_q <= cfg_data_i;
  end

  sstft_front #(.FftSize(FftSize)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser), .coeff_index_i(s_axis_tdata[5:0]),
    .window_coeff_i(s_axis_tdata[21:6]), .sample_i(s_axis_tdata[37:22]),
    .overlap_i(ovl_q), .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  sstft_engine #(.FftSize(FftSize)) u_engine (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .frame_o(fr), .bin_o(bn), .re_o(re), .im_o(im), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, im, re, bn, fr};
endmodule

// File: rtl/sstft_front.sv
// ----------------------------------------------------------------------------
// sstft_front
// Accepts input words, tracks fill and hop counts, and queues decoded jobs.
// ----------------------------------------------------------------------------
module sstft_front #(
  parameter int unsigned FftSize = sstft_pkg::FftSizeDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [5:0]                coeff_index_i,
  input  logic [15:0]               window_coeff_i,
  input  logic [15:0]               sample_i,
  input  logic [sstft_pkg::OvlW-1:0] overlap_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output sstft_pkg::job_t           job_o
);
  import sstft_pkg::*;

  localparam int unsigned CntW = $clog2(FftSize + 1);

  logic [CntW-1:0] seen_q, seen_d;
  logic [5:0]      hop_q, hop_d;
  job_t            q0_q, q1_q, new_job;
  logic [1:0]      cnt_q;
  logic            push, pop;
  logic [6:0]      ov, hop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop  = job_valid_o && job_ready_i;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o = q0_q;

  always_comb begin
    ov = {1'b0, overlap_i};
    if (ov >= 7'(FftSize)) ov = 7'(FftSize - 1);
    hop = 7'(FftSize) - ov;
    seen_d = seen_q;
    hop_d  = hop_q;
    new_job.is_sample = (cmd_i == CmdSamp);
    new_job.index = coeff_index_i;
    new_job.value = (cmd_i == CmdSamp) ? sample_i : window_coeff_i;
    new_job.fire = 1'b0;
    if (cmd_i == CmdSamp) begin
      if (seen_q < CntW'(FftSize)) begin
        seen_d = seen_q + 1'b1;
        if (seen_d == CntW'(FftSize)) begin
          hop_d = '0;
          new_job.fire = 1'b1;
        end
      end else if ({1'b0, hop_q} + 7'd1 >= hop) begin
        hop_d = '0;
        new_job.fire = 1'b1;
      end else begin
        hop_d = hop_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      hop_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        seen_q <= seen_d;
        hop_q  <= hop_d;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Two-entry queue; entry 0 is the head.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      q0_q <= (cnt_q == 2'd2) ? q1_q : new_job;
      if (push && cnt_q == 2'd2) q1_q <= new_job;
    end else if (push) begin
      if (cnt_q == 2'd0) q0_q <= new_job;
      else q1_q <= new_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("job queue count corrupt");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_ready_o) else $error("accept while queue full");
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= CntW'(FftSize)) else $error("fill count beyond frame");
`endif
endmodule

// File: rtl/sstft_engine.sv
// ----------------------------------------------------------------------------
// sstft_engine
// Stores window and samples, then computes each bin as a serial DFT sum.
// ----------------------------------------------------------------------------
module sstft_engine #(
  parameter int unsigned FftSize = sstft_pkg::FftSizeDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  sstft_pkg::job_t job_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     frame_o,
  output logic [5:0]      bin_o,
  output logic [31:0]     re_o,
  output logic [31:0]     im_o,
  output logic            last_o
);
  import sstft_pkg::*;

  localparam int unsigned NW = $clog2(FftSize);
  localparam int unsigned Step = 64 / FftSize;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_PROD = 5'b00010, S_ACC = 5'b00100,
    S_DONE = 5'b01000, S_OUT = 5'b10000
  } state_e;

  state_e state_q;
  logic [15:0] win_mem [64];
  logic [15:0] smp_mem [FftSize];
  logic signed [32:0] work_mem [FftSize];
  logic [NW-1:0] head_q;            // oldest sample position
  logic [NW:0]   n_q;
  logic [5:0]    k_q;
  logic [15:0]   frame_q;
  logic [15:0]   smp_rd_q, win_rd_q;
  logic signed [32:0] p_q;
  logic [5:0]    m_q;
  logic          pv_q;
  logic signed [AccW-1:0] re_acc_q, im_acc_q;
  logic signed [50:0] mr_q, mi_q;
  logic          mv_q;
  logic [NW-1:0] rd_n;
  logic [5:0]    m_next;
  logic signed [AccW-1:0] rr, ri;
  logic signed [32:0] w_rd_q;
  logic [NW-1:0] wr_n_q;
  logic          wr_en_q;

  assign job_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign m_next = 6'((k_q * n_q[NW-1:0]) & (FftSize - 1)) * 6'(Step);
  assign rd_n = head_q + n_q[NW-1:0];

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      if (!job_i.is_sample) win_mem[job_i.index] <= job_i.value;
      else smp_mem[head_q] <= job_i.value;
    end
    smp_rd_q <= smp_mem[rd_n];
    win_rd_q <= win_mem[6'(n_q[NW-1:0])];
    p_q <= 33'($signed(smp_rd_q) * $signed({1'b0, win_rd_q}));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_q) work_mem[wr_n_q] <= p_q;
    w_rd_q <= work_mem[n_q[NW-1:0]];
    mr_q <= 51'(w_rd_q * cos64(m_q));
    mi_q <= 51'(w_rd_q * sin64(m_q));
  end

  always_comb begin
    rr = (re_acc_q + (64'sd1 <<< 29)) >>> 30;
    ri = (im_acc_q + (64'sd1 <<< 29)) >>> 30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= '0;
      n_q <= '0;
      k_q <= '0;
      frame_q <= '0;
      wr_en_q <= 1'b0;
      pv_q <= 1'b0;
      mv_q <= 1'b0;
    end else begin
      // The product of position n reaches p_q in the cycle after pv_q marks it.
      wr_en_q <= (state_q == S_PROD) && pv_q;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i && job_i.is_sample) begin
            head_q <= head_q + 1'b1;
            if (job_i.fire) begin
              state_q <= S_PROD;
              n_q <= '0;
              pv_q <= 1'b0;
            end
          end
        end
        S_PROD: begin
          // Read sample and window; the product is formed in the next cycle.
          wr_n_q <= n_q[NW-1:0] - NW'(1);
          if (n_q == (NW+1)'(FftSize)) begin
            state_q <= S_ACC;
            n_q <= '0;
            k_q <= '0;
            pv_q <= 1'b0;
            mv_q <= 1'b0;
            re_acc_q <= '0;
            im_acc_q <= '0;
          end else begin
            n_q <= n_q + 1'b1;
            pv_q <= 1'b1;
          end
        end
        S_ACC: begin
          m_q <= m_next;
          pv_q <= (n_q < (NW+1)'(FftSize));
          mv_q <= pv_q;
          if (mv_q) begin
            re_acc_q <= re_acc_q + AccW'(mr_q);
            im_acc_q <= im_acc_q - AccW'(mi_q);
          end
          if (n_q < (NW+1)'(FftSize + 2)) n_q <= n_q + 1'b1;
          else state_q <= S_DONE;
        end
        S_DONE: begin
          frame_o <= frame_q;
          bin_o <= k_q;
          re_o <= rr[31:0];
          im_o <= (k_q == 6'd0 || k_q == 6'(FftSize / 2)) ? 32'd0 : ri[31:0];
          last_o <= (k_q == 6'(FftSize / 2));
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            re_acc_q <= '0;
            im_acc_q <= '0;
            n_q <= '0;
            pv_q <= 1'b0;
            mv_q <= 1'b0;
            if (last_o) begin
              frame_q <= frame_q + 16'd1;
              state_q <= S_IDLE;
            end else begin
              k_q <= k_q + 6'd1;
              state_q <= S_ACC;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(re_o))
    else $error("result dropped");
  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bin_o <= 6'(FftSize / 2)) else $error("bin index out of range");
`endif
endmodule
